// ===== design/emxp_pkg.sv =====
// ----------------------------------------------------------------------------
// emxp_pkg
// shared constants, types and helpers for the expression maximiser
// ----------------------------------------------------------------------------
package emxp_pkg;

  localparam int MAX_OPERANDS = 16;
  localparam int IDX_W        = $clog2(MAX_OPERANDS);
  localparam int CNT_W        = $clog2(MAX_OPERANDS + 1);
  localparam int ADDR_W       = 2 * IDX_W;
  localparam int DIGIT_W      = 4;
  localparam int OPC_W        = 2;
  localparam int VAL_W        = 64;
  localparam int HALF_W       = VAL_W / 2;

  typedef logic signed [VAL_W-1:0] value_t;

  localparam value_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam value_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [OPC_W-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2
  } op_t;

  // request into the combine pipeline
  typedef struct packed {
    logic valid;
    op_t  op;
  } issue_t;

  // candidate value leaving the combine pipeline
  typedef struct packed {
    logic   valid;
    value_t value;
  } cand_t;

  // the unused operator code folds onto add
  function automatic op_t decode_op(logic [OPC_W-1:0] code);
    op_t op;
    if (code == OP_SUB) begin
      op = OP_SUB;
    end else if (code == OP_MUL) begin
      op = OP_MUL;
    end else begin
      op = OP_ADD;
    end
    return op;
  endfunction

endpackage

// ===== design/emxp_channels.sv =====
// ----------------------------------------------------------------------------
// emxp channels
// valid/ready channels for operand requests and results
// ----------------------------------------------------------------------------
interface emxp_in_if;
  import emxp_pkg::*;

  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] operand;
  logic [OPC_W-1:0]   opcode;
  logic               last;

  modport source (output valid, operand, opcode, last, input ready);
  modport sink   (input valid, operand, opcode, last, output ready);
endinterface

interface emxp_out_if;
  import emxp_pkg::*;

  logic   valid;
  logic   ready;
  value_t max_value;

  modport source (output valid, max_value, input ready);
  modport sink   (input valid, max_value, output ready);
endinterface

// ===== design/emxp_dpram.sv =====
// ----------------------------------------------------------------------------
// emxp_dpram
// synchronous ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module emxp_dpram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== design/emxp_combine.sv =====
// ----------------------------------------------------------------------------
// emxp_combine
// two-stage add / subtract / multiply of one candidate pair, 64-bit wrap
// ----------------------------------------------------------------------------
module emxp_combine (
  input  logic            clk,
  input  logic            rst,
  input  emxp_pkg::issue_t issue,
  input  emxp_pkg::value_t x,
  input  emxp_pkg::value_t y,
  output emxp_pkg::cand_t  cand
);
  import emxp_pkg::*;

  logic                  s1_valid;
  op_t                   s1_op;
  value_t                s1_sum;
  logic [2*HALF_W-1:0]   s1_ll;
  logic [HALF_W-1:0]     s1_lh;
  logic [HALF_W-1:0]     s1_hl;
  logic [2*HALF_W-1:0]   prod_lh;
  logic [2*HALF_W-1:0]   prod_hl;
  value_t                sum_next;
  logic [VAL_W-1:0]      mul_val;
  logic [HALF_W-1:0]     cross_sum;
  logic                  c_valid;
  value_t                c_value;

  // only the low halves of the cross products reach the wrapped result
  always_comb begin
    prod_lh = x[HALF_W-1:0] * y[VAL_W-1:HALF_W];
    prod_hl = x[VAL_W-1:HALF_W] * y[HALF_W-1:0];
    case (issue.op)
      OP_SUB:  sum_next = x - y;
      default: sum_next = x + y;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      c_valid  <= 1'b0;
    end else begin
      s1_valid <= issue.valid;
      c_valid  <= s1_valid;
    end
  end

  always_comb begin
    cross_sum = s1_lh + s1_hl;
    mul_val   = s1_ll + {cross_sum, {HALF_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    s1_op   <= issue.op;
    s1_sum  <= sum_next;
    s1_ll   <= x[HALF_W-1:0] * y[HALF_W-1:0];
    s1_lh   <= prod_lh[HALF_W-1:0];
    s1_hl   <= prod_hl[HALF_W-1:0];
    c_value <= (s1_op == OP_MUL) ? value_t'(mul_val) : s1_sum;
  end

  assign cand = '{valid: c_valid, value: c_value};

endmodule

// ===== design/expression_max_by_parenthesization.sv =====
// ----------------------------------------------------------------------------
// expression_max_by_parenthesization
// largest value of a digit expression over all bracketings, interval dp
// ----------------------------------------------------------------------------
// Operands arrive one request at a time: a digit, the operator after it
// (add, subtract, multiply; the spare code counts as add) and a last flag.
// Up to 16 operands are kept; further ones are dropped, though a dropped
// request flagged last still starts evaluation. A non-last request leaves
// the block idle and ready for the next. After the last one the block
// seeds the diagonal of two 256-entry span tables (minimum and maximum),
// then visits every split of every span: a read state for the span rams,
// an issue state that sends the four min/max pairings through the shared
// combine pipeline, and a drain state that empties it. The result waits
// in an output register, and new operands are taken while it is still
// unread. Arithmetic wraps modulo 2^64, which cannot happen with decimal
// digits.
// ----------------------------------------------------------------------------
module expression_max_by_parenthesization (
  input logic       clk,
  input logic       rst,
  emxp_in_if.sink   operands,
  emxp_out_if.source result
);
  import emxp_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_INIT   = 6'b000010,
    ST_READ   = 6'b000100,
    ST_CALC   = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state;

  // operand and operator stores
  logic [DIGIT_W-1:0] operand_store  [MAX_OPERANDS];
  op_t                operator_store [MAX_OPERANDS];
  logic [CNT_W-1:0]   operand_count;
  logic [CNT_W-1:0]   n_ops;
  logic [CNT_W-1:0]   n_minus_one;
  logic               store_ok;
  logic               accept;

  // span walk: row i, span length s, split k, candidate select
  logic [IDX_W-1:0]   row;
  logic [IDX_W-1:0]   span_len;
  logic [IDX_W-1:0]   split;
  logic [IDX_W-1:0]   col;
  logic [IDX_W-1:0]   last_idx;
  logic [IDX_W-1:0]   split_inc;
  logic [IDX_W-1:0]   row_inc;
  logic [1:0]         cand_sel;
  logic               split_last;
  logic               span_final;

  // running extremes of the span under evaluation
  value_t             span_lo;
  value_t             span_hi;
  value_t             lo_next;
  value_t             hi_next;
  value_t             diag_value;
  value_t             res_value;

  // span ram ports
  logic               span_we;
  logic [ADDR_W-1:0]  span_waddr;
  value_t             wr_lo;
  value_t             wr_hi;
  logic [ADDR_W-1:0]  raddr_left;
  logic [ADDR_W-1:0]  raddr_right;
  value_t             min_left;
  value_t             min_right;
  value_t             max_left;
  value_t             max_right;

  // combine pipeline
  issue_t             issue;
  value_t             cand_x;
  value_t             cand_y;
  cand_t              cand;

  // result register
  logic               out_valid;
  value_t             out_value;
  logic               out_load;

  assign accept      = operands.valid && operands.ready;
  assign operands.ready = (state == ST_IDLE);
  assign store_ok    = operand_count < CNT_W'(MAX_OPERANDS);

  assign n_minus_one = n_ops - CNT_W'(1);
  assign last_idx    = n_minus_one[IDX_W-1:0];
  assign col         = row + span_len;
  assign split_inc   = split + IDX_W'(1);
  assign row_inc     = row + IDX_W'(1);
  assign split_last  = (split_inc == col);
  // the whole expression is the span from operand 0 to the last one
  assign span_final  = split_last && (col == last_idx) && (row == '0);

  assign diag_value  = {{(VAL_W-DIGIT_W){1'b0}}, operand_store[row]};

  // left part is span (i,k), right part is span (k+1,j)
  assign raddr_left  = {row, split};
  assign raddr_right = {split_inc, col};

  emxp_dpram #(
    .ADDR_W (ADDR_W),
    .DATA_W (VAL_W)
  ) u_min_ram (
    .clk     (clk),
    .we      (span_we),
    .waddr   (span_waddr),
    .wdata   (wr_lo),
    .raddr_a (raddr_left),
    .raddr_b (raddr_right),
    .rdata_a (min_left),
    .rdata_b (min_right)
  );

  emxp_dpram #(
    .ADDR_W (ADDR_W),
    .DATA_W (VAL_W)
  ) u_max_ram (
    .clk     (clk),
    .we      (span_we),
    .waddr   (span_waddr),
    .wdata   (wr_hi),
    .raddr_a (raddr_left),
    .raddr_b (raddr_right),
    .rdata_a (max_left),
    .rdata_b (max_right)
  );

  // pairings in order: max/max, max/min, min/max, min/min
  assign cand_x = cand_sel[1] ? min_left  : max_left;
  assign cand_y = cand_sel[0] ? min_right : max_right;
  assign issue  = '{valid: (state == ST_CALC), op: operator_store[split]};

  emxp_combine u_combine (
    .clk   (clk),
    .rst   (rst),
    .issue (issue),
    .x     (cand_x),
    .y     (cand_y),
    .cand  (cand)
  );

  // fold each candidate into the running extremes
  always_comb begin
    lo_next = span_lo;
    hi_next = span_hi;
    if (cand.valid && (cand.value < span_lo)) begin
      lo_next = cand.value;
    end
    if (cand.valid && (cand.value > span_hi)) begin
      hi_next = cand.value;
    end
  end

  // ram writes: diagonal seeding, then one entry per finished span
  always_comb begin
    span_we    = 1'b0;
    span_waddr = {row, row};
    wr_lo      = diag_value;
    wr_hi      = diag_value;
    if (state == ST_INIT) begin
      span_we = 1'b1;
    end else if ((state == ST_DRAIN) && cand_sel[0] && split_last) begin
      span_we    = 1'b1;
      span_waddr = {row, col};
      wr_lo      = lo_next;
      wr_hi      = hi_next;
    end
  end

  assign out_load = (state == ST_FINISH) && (!out_valid || result.ready);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      operand_count <= '0;
      cand_sel      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (store_ok) begin
              operand_count <= operand_count + CNT_W'(1);
            end
            if (operands.last) begin
              operand_count <= '0;
              state         <= ST_INIT;
            end
          end
        end
        ST_INIT: begin
          if (row == last_idx) begin
            state <= (last_idx == '0) ? ST_FINISH : ST_READ;
          end
        end
        ST_READ: begin
          cand_sel <= '0;
          state    <= ST_CALC;
        end
        ST_CALC: begin
          cand_sel <= cand_sel + 2'b01;
          if (cand_sel == '1) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (cand_sel[0]) begin
            cand_sel <= '0;
            state    <= span_final ? ST_FINISH : ST_READ;
          end else begin
            cand_sel <= cand_sel + 2'b01;
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept && store_ok) begin
      operand_store[operand_count[IDX_W-1:0]]  <= operands.operand;
      operator_store[operand_count[IDX_W-1:0]] <= decode_op(operands.opcode);
    end
    if (accept && operands.last) begin
      n_ops <= store_ok ? (operand_count + CNT_W'(1)) : operand_count;
      row   <= '0;
    end

    span_lo <= lo_next;
    span_hi <= hi_next;

    if (state == ST_INIT) begin
      if (row == last_idx) begin
        if (last_idx == '0) begin
          // single operand
          res_value <= diag_value;
        end else begin
          span_len <= IDX_W'(1);
          row      <= '0;
          split    <= '0;
          span_lo  <= VAL_MAX;
          span_hi  <= VAL_MIN;
        end
      end else begin
        row <= row_inc;
      end
    end

    if ((state == ST_DRAIN) && cand_sel[0]) begin
      if (!split_last) begin
        split <= split_inc;
      end else if (span_final) begin
        res_value <= hi_next;
      end else begin
        if (col == last_idx) begin
          // next span length starts at row 0
          span_len <= span_len + IDX_W'(1);
          row      <= '0;
          split    <= '0;
        end else begin
          row   <= row_inc;
          split <= row_inc;
        end
        span_lo <= VAL_MAX;
        span_hi <= VAL_MIN;
      end
    end

    if (out_load) begin
      out_value <= res_value;
    end
  end

  assign result.valid     = out_valid;
  assign result.max_value = out_value;

  // the operand count is cleared by every last request
  a_count_cleared: assert property (@(posedge clk) disable iff (rst)
    (accept && operands.last) |=> (operand_count == '0))
    else $error("operand count not cleared after last request");

  // a result only appears out of the finish state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result raised outside finish state");

  // span entries are only ever written for row <= column
  a_span_order: assert property (@(posedge clk) disable iff (rst)
    span_we |-> (span_waddr[ADDR_W-1:IDX_W] <= span_waddr[IDX_W-1:0]))
    else $error("span write below the diagonal");

  // combine results land only while a split is being evaluated
  a_cand_window: assert property (@(posedge clk) disable iff (rst)
    cand.valid |-> ((state == ST_CALC) || (state == ST_DRAIN)))
    else $error("candidate outside split evaluation");

endmodule
